// ===== design/tss_pkg.sv =====
package tss_pkg;

  localparam int FRAC_BITS = 24;
  localparam int ANGLE_W = 32;
  localparam int TERMS_W = 6;
  localparam int TOL_W = 24;
  localparam logic [TOL_W-1:0] TOL_RESET = 24'd16777;
  localparam int DEF_MAX_TERMS = 32;

  // 6.28 in the angle format, rounded to nearest.
  localparam longint unsigned MOD_628_FULL = ((64'd628 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [ANGLE_W-1:0] MOD_628 = ANGLE_W'(MOD_628_FULL);
  localparam int XMAG_W = $clog2(MOD_628_FULL);

  // Term magnitudes stay below 2^31 for any reduced angle, so the quotient
  // of every term update fits in TMAG_W bits.
  localparam int TMAG_W = 32;
  localparam int P1_W = TMAG_W + XMAG_W - FRAC_BITS;
  localparam int P2_W = P1_W + XMAG_W - FRAC_BITS;
  localparam int BITCNT_W = $clog2(TMAG_W);
  localparam int SH_W = 3;
  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RED,
    OP_INIT,
    OP_CHECK,
    OP_ADD,
    OP_MUL1,
    OP_MUL2,
    OP_DIVI,
    OP_DIVS,
    OP_NEXT,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_STOP,
    JMP_DIV
  } jmp_t;

  typedef struct packed {
    op_t              op;
    logic [SH_W-1:0]  red_sh;
    jmp_t             jmp;
    step_t            target;
  } uword_t;

  typedef struct packed {
    logic             load;
    op_t              op;
    logic [SH_W-1:0]  red_sh;
  } ctl_t;

  typedef struct packed {
    logic stop;
    logic div_more;
  } status_t;

  localparam step_t ST_RED0 = 4'd0;
  localparam step_t ST_CHECK = 4'd6;
  localparam step_t ST_DIV = 4'd11;
  localparam step_t ST_DONE = 4'd13;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{op: OP_NOP, red_sh: '0, jmp: JMP_ALWAYS, target: ST_DONE};
    unique case (s)
      4'd0:  w = '{op: OP_RED,   red_sh: 3'd4, jmp: JMP_NEVER,  target: ST_RED0};
      4'd1:  w = '{op: OP_RED,   red_sh: 3'd3, jmp: JMP_NEVER,  target: ST_RED0};
      4'd2:  w = '{op: OP_RED,   red_sh: 3'd2, jmp: JMP_NEVER,  target: ST_RED0};
      4'd3:  w = '{op: OP_RED,   red_sh: 3'd1, jmp: JMP_NEVER,  target: ST_RED0};
      4'd4:  w = '{op: OP_RED,   red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      4'd5:  w = '{op: OP_INIT,  red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      4'd6:  w = '{op: OP_CHECK, red_sh: 3'd0, jmp: JMP_STOP,   target: ST_DONE};
      4'd7:  w = '{op: OP_ADD,   red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      4'd8:  w = '{op: OP_MUL1,  red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      4'd9:  w = '{op: OP_MUL2,  red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      4'd10: w = '{op: OP_DIVI,  red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      4'd11: w = '{op: OP_DIVS,  red_sh: 3'd0, jmp: JMP_DIV,    target: ST_DIV};
      4'd12: w = '{op: OP_NEXT,  red_sh: 3'd0, jmp: JMP_ALWAYS, target: ST_CHECK};
      4'd13: w = '{op: OP_DONE,  red_sh: 3'd0, jmp: JMP_NEVER,  target: ST_RED0};
      default: w = '{op: OP_NOP, red_sh: 3'd0, jmp: JMP_ALWAYS, target: ST_DONE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/taylor_sine_with_tolerance.sv =====
// From the accepted request to the done strobe, the sequencer adds series terms one at a time,
// at most MAX_TERMS of them, until a term no longer exceeds the tolerance.
// Each term takes 38 steps of the microcode program, 32 of them in the bit-serial divider.
// Only one request is taken at a time; busy stays high until done has shown.
// Reset is synchronous and active high; it idles the sequencer and sets tolerance to 16777.
// Results are shown for one cycle with done high; the receiver cannot stall them.
module taylor_sine_with_tolerance #(
  parameter int MAX_TERMS = tss_pkg::DEF_MAX_TERMS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tss_pkg::ANGLE_W-1:0]  angle,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tss_pkg::TOL_W-1:0]           cfg_data,
  output logic                                done,
  output logic signed [tss_pkg::ANGLE_W-1:0]  sine_value,
  output logic [tss_pkg::TERMS_W-1:0]         terms_used,
  output logic                                limit_hit
);
  import tss_pkg::*;

  logic [TOL_W-1:0] tolerance;
  step_t            step;
  step_t            step_next;
  uword_t           uword;
  ctl_t             ctl;
  status_t          status;
  logic             accept;
  logic             jump;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign uword = ucode(step);

  always_comb begin
    unique case (uword.jmp)
      JMP_NEVER:  jump = 1'b0;
      JMP_ALWAYS: jump = 1'b1;
      JMP_STOP:   jump = status.stop;
      JMP_DIV:    jump = status.div_more;
      default:    jump = 1'b0;
    endcase
    step_next = jump ? uword.target : step + 1'b1;
  end

  assign ctl.load = accept;
  assign ctl.op = busy ? uword.op : OP_NOP;
  assign ctl.red_sh = uword.red_sh;
  assign done = busy && (uword.op == OP_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      busy <= 1'b0;
      step <= ST_RED0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tolerance <= cfg_data;
      end
      if (accept) begin
        busy <= 1'b1;
        step <= ST_RED0;
      end else if (busy) begin
        if (uword.op == OP_DONE) begin
          busy <= 1'b0;
          step <= ST_RED0;
        end else begin
          step <= step_next;
        end
      end
    end
  end

  tss_datapath #(
    .MAX_TERMS(MAX_TERMS)
  ) u_datapath (
    .clk       (clk),
    .ctl       (ctl),
    .angle     (angle),
    .tol       (tolerance),
    .status    (status),
    .sine_value(sine_value),
    .terms_used(terms_used),
    .limit_hit (limit_hit)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done strobe outside a busy period");
  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after done");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && step == ST_RED0))
    else $error("accepted request did not start the program");
  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    (done && limit_hit) |-> (terms_used == TERMS_W'(MAX_TERMS)))
    else $error("term limit flagged with wrong term count");

endmodule

// ===== design/tss_datapath.sv =====
module tss_datapath #(
  parameter int MAX_TERMS = tss_pkg::DEF_MAX_TERMS
) (
  input  logic                                clk,
  input  tss_pkg::ctl_t                       ctl,
  input  logic signed [tss_pkg::ANGLE_W-1:0]  angle,
  input  logic [tss_pkg::TOL_W-1:0]           tol,
  output tss_pkg::status_t                    status,
  output logic signed [tss_pkg::ANGLE_W-1:0]  sine_value,
  output logic [tss_pkg::TERMS_W-1:0]         terms_used,
  output logic                                limit_hit
);
  import tss_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int D_W = 2 * CNT_W + 2;
  localparam int PR1_W = TMAG_W + XMAG_W;
  localparam int PR2_W = P1_W + XMAG_W;
  localparam int RED_CMP_W = ANGLE_W + (1 << SH_W);

  logic                       xneg;
  logic [ANGLE_W-1:0]         red;
  logic [XMAG_W-1:0]          xmag;
  logic                       tneg;
  logic [TMAG_W-1:0]          tmag;
  logic signed [ANGLE_W-1:0]  sum;
  logic [CNT_W-1:0]           count;
  logic                       limit;
  logic [P2_W-1:0]            p;
  logic [D_W-1:0]             d;
  logic [D_W-1:0]             rem;
  logic [TMAG_W-1:0]          q;
  logic [BITCNT_W-1:0]        bitcnt;

  logic [ANGLE_W-1:0]         angle_mag;
  logic [RED_CMP_W-1:0]       mod_sh;
  logic [RED_CMP_W-1:0]       red_ext;
  logic                       over_tol;
  logic                       at_max;
  logic signed [ANGLE_W+1:0]  sum_wide;
  logic [ANGLE_W+1:0]         term_ext;
  logic [PR1_W-1:0]           prod1;
  logic [PR2_W-1:0]           prod2;
  logic [D_W-1:0]             d_calc;
  logic [D_W:0]               rem_shift;
  logic [D_W:0]               rem_diff;
  logic [CNT_W+TERMS_W-1:0]   count_ext;

  assign angle_mag = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
  assign mod_sh = {{(RED_CMP_W-ANGLE_W){1'b0}}, MOD_628} << ctl.red_sh;
  assign red_ext = {{(RED_CMP_W-ANGLE_W){1'b0}}, red};

  assign over_tol = tmag > {{(TMAG_W-TOL_W){1'b0}}, tol};
  assign at_max = count == CNT_W'(MAX_TERMS);
  assign status.stop = !over_tol || at_max;
  assign status.div_more = bitcnt != '0;

  assign term_ext = {2'b00, tmag};
  assign sum_wide = {{2{sum[ANGLE_W-1]}}, sum} + (tneg ? (~term_ext + 1'b1) : term_ext);

  assign prod1 = {{XMAG_W{1'b0}}, tmag} * {{TMAG_W{1'b0}}, xmag};
  assign prod2 = {{XMAG_W{1'b0}}, p[P1_W-1:0]} * {{P1_W{1'b0}}, xmag};
  assign d_calc = {{(CNT_W+1){1'b0}}, count, 1'b0} * {{(CNT_W+1){1'b0}}, count, 1'b1};

  assign rem_shift = {rem, q[TMAG_W-1]};
  assign rem_diff = rem_shift - {1'b0, d};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      red <= angle_mag;
      xneg <= angle[ANGLE_W-1];
    end
    unique case (ctl.op)
      OP_RED: begin
        if (red_ext >= mod_sh) begin
          red <= ANGLE_W'(red_ext - mod_sh);
        end
      end
      OP_INIT: begin
        xmag <= red[XMAG_W-1:0];
        tmag <= TMAG_W'(red);
        tneg <= xneg && (red != '0);
        sum <= '0;
        count <= '0;
        limit <= 1'b0;
      end
      OP_CHECK: begin
        limit <= at_max && over_tol;
      end
      OP_ADD: begin
        if (sum_wide[ANGLE_W+1:ANGLE_W-1] != '0 && sum_wide[ANGLE_W+1:ANGLE_W-1] != '1) begin
          sum <= sum_wide[ANGLE_W+1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                     : {1'b0, {(ANGLE_W-1){1'b1}}};
        end else begin
          sum <= sum_wide[ANGLE_W-1:0];
        end
        count <= count + 1'b1;
      end
      OP_MUL1: begin
        p <= P2_W'(prod1[PR1_W-1:FRAC_BITS]);
        d <= d_calc;
      end
      OP_MUL2: begin
        p <= prod2[PR2_W-1:FRAC_BITS];
      end
      OP_DIVI: begin
        rem <= D_W'(p[P2_W-1:TMAG_W]);
        q <= p[TMAG_W-1:0];
        bitcnt <= '1;
      end
      OP_DIVS: begin
        if (!rem_diff[D_W]) begin
          rem <= rem_diff[D_W-1:0];
          q <= {q[TMAG_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift[D_W-1:0];
          q <= {q[TMAG_W-2:0], 1'b0};
        end
        bitcnt <= bitcnt - 1'b1;
      end
      OP_NEXT: begin
        tmag <= q;
        tneg <= !tneg;
      end
      OP_NOP, OP_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign count_ext = {{TERMS_W{1'b0}}, count};
  assign sine_value = sum;
  assign terms_used = count_ext[TERMS_W-1:0];
  assign limit_hit = limit;

endmodule
